// File: rtl/mail_sender_address_extractor_top_assert.svh
// Assertion macros for the sender address extractor.
// Used by the datapath module; depends on nothing else.
`ifndef MAIL_SENDER_ADDRESS_EXTRACTOR_TOP_ASSERT_SVH
`define MAIL_SENDER_ADDRESS_EXTRACTOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mse_pkg.sv
// Shared types and constants of the sender address extractor.
// Used by the controller, the datapath and the top level; depends on nothing.
package mse_pkg;

  // Datapath operations issued by the controller.
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_MATCH     = 3'd1;
  localparam logic [2:0] OP_HELD_A    = 3'd2;
  localparam logic [2:0] OP_HELD_T    = 3'd3;
  localparam logic [2:0] OP_PROCESS   = 3'd4;
  localparam logic [2:0] OP_EMIT_ERR  = 3'd5;
  localparam logic [2:0] OP_EMIT_CHAR = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_UNSAFE = 2'd2;
  localparam logic [1:0] ST_LONG   = 2'd3;

  // Progress of the at-word lookahead.
  localparam logic [1:0] MP_IDLE  = 2'd0;
  localparam logic [1:0] MP_SPACE = 2'd1;
  localparam logic [1:0] MP_A     = 2'd2;
  localparam logic [1:0] MP_AT    = 2'd3;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_T   = 8'h54;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_MAX_DEPTH = 8'hFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic [2:0] op;
  } mse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       finished;
    logic       match_hit;
    logic [1:0] match_progress;
    logic       eval_ok;
    logic       emit_last;
    logic       out_free;
  } mse_sts_t;

  // True for characters that must not appear in a delivered address.
  function automatic logic is_unsafe(input logic [7:0] c);
    logic res;
    res = c[7];
    case (c)
      CH_DQUOTE, CH_SQUOTE, CH_BTICK, CH_DOLLAR, CH_NL, CH_SEMI, CH_AMP,
      CH_PIPE, CH_CARET, CH_LT, CH_GT, CH_LPAREN, CH_RPAREN, CH_BSLASH: begin
        res = 1'b1;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

endpackage

// File: rtl/mse_in_if.sv
// Input channel of the sender address extractor: one line character or an end mark.
// Depends on nothing.
interface mse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_line;

  modport source (output valid, output char_byte, output end_of_line, input ready);
  modport sink (input valid, input char_byte, input end_of_line, output ready);
endinterface

// File: rtl/mse_out_if.sv
// Output channel of the sender address extractor: one address character or error.
// Depends on nothing.
interface mse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] addr_char;
  logic [1:0] status;
  logic       last_char;

  modport source (output valid, output addr_char, output status, output last_char,
                  input ready);
  modport sink (input valid, input addr_char, input status, input last_char,
                output ready);
endinterface

// File: rtl/mse_ctrl.sv
// Controller of the sender address extractor: sequences the steps of each item.
// Depends on mse_pkg.
module mse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_end_of_line,
  output logic              in_ready,
  input  mse_pkg::mse_sts_t sts,
  output mse_pkg::mse_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MATCH   = 4'd1;
  localparam logic [3:0] S_HELD_T  = 4'd2;
  localparam logic [3:0] S_PROCESS = 4'd3;
  localparam logic [3:0] S_END     = 4'd4;
  localparam logic [3:0] S_END_T   = 4'd5;
  localparam logic [3:0] S_EVAL    = 4'd6;
  localparam logic [3:0] S_READ    = 4'd7;
  localparam logic [3:0] S_LOAD    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = mse_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = in_end_of_line ? S_END : S_MATCH;
        end
      end
      S_MATCH: begin
        if (sts.finished) begin
          state_next = S_IDLE;
        end else if (sts.match_hit) begin
          cmd.op     = mse_pkg::OP_MATCH;
          state_next = S_IDLE;
        end else if (sts.match_progress == mse_pkg::MP_A) begin
          cmd.op     = mse_pkg::OP_HELD_A;
          state_next = S_PROCESS;
        end else if (sts.match_progress == mse_pkg::MP_AT) begin
          cmd.op     = mse_pkg::OP_HELD_A;
          state_next = S_HELD_T;
        end else begin
          cmd.op     = mse_pkg::OP_PROCESS;
          state_next = S_IDLE;
        end
      end
      S_HELD_T: begin
        cmd.op     = mse_pkg::OP_HELD_T;
        state_next = S_PROCESS;
      end
      S_PROCESS: begin
        cmd.op     = mse_pkg::OP_PROCESS;
        state_next = S_IDLE;
      end
      S_END: begin
        if (sts.match_progress == mse_pkg::MP_A) begin
          cmd.op     = mse_pkg::OP_HELD_A;
          state_next = S_EVAL;
        end else if (sts.match_progress == mse_pkg::MP_AT) begin
          cmd.op     = mse_pkg::OP_HELD_A;
          state_next = S_END_T;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_END_T: begin
        cmd.op     = mse_pkg::OP_HELD_T;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.eval_ok) begin
          state_next = S_READ;
        end else if (sts.out_free) begin
          cmd.op     = mse_pkg::OP_EMIT_ERR;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.op     = mse_pkg::OP_EMIT_CHAR;
          state_next = sts.emit_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/mse_datapath.sv
// Datapath of the sender address extractor: parse state, address buffer, result register.
// Depends on mse_pkg and the assertion macro header.
`include "mail_sender_address_extractor_top_assert.svh"

module mse_datapath #(
  parameter int ADDR_CHARS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  mse_pkg::mse_cmd_t cmd,
  output mse_pkg::mse_sts_t sts,
  input  logic [7:0]        char_byte,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        addr_char,
  output logic [1:0]        status,
  output logic              last_char
);

  localparam int IDX_W = $clog2(ADDR_CHARS + 1);
  localparam int AW    = $clog2(ADDR_CHARS);

  // Address buffer and its registered read port.
  logic [7:0] addr_buffer [ADDR_CHARS];
  logic [7:0] rd_data;

  // Parse state.
  logic [7:0]       char_q;
  logic [IDX_W-1:0] write_index;
  logic             chop_valid;
  logic [IDX_W-1:0] chop_index;
  logic [7:0]       comment_depth;
  logic             in_angle;
  logic             finished;
  logic [1:0]       match_progress;
  logic             match_upper;
  logic             unsafe_seen;
  logic             overflow_seen;
  logic [IDX_W-1:0] rd_index;

  logic             store_en;
  logic [7:0]       store_char;
  logic             do_store;
  logic             do_write;
  logic             plain_char;
  logic [IDX_W-1:0] addr_len;
  logic [1:0]       eval_status;
  logic             emit_last;
  logic             out_free;
  logic             clear_now;

  // A character that reaches the buffer when it is processed outside a comment.
  always_comb begin
    plain_char = 1'b1;
    case (char_q)
      mse_pkg::CH_NUL, mse_pkg::CH_TAB, mse_pkg::CH_NL, mse_pkg::CH_SPACE,
      mse_pkg::CH_LT, mse_pkg::CH_LPAREN, mse_pkg::CH_COMMA: begin
        plain_char = 1'b0;
      end
      default: begin
      end
    endcase
    if (comment_depth != 8'd0) begin
      plain_char = 1'b0;
    end
    if (in_angle && (char_q == mse_pkg::CH_GT)) begin
      plain_char = 1'b0;
    end
  end

  // Select the character written by this step, if any.
  always_comb begin
    store_en   = 1'b0;
    store_char = char_q;
    case (cmd.op)
      mse_pkg::OP_MATCH: begin
        store_en   = (match_progress == mse_pkg::MP_AT);
        store_char = mse_pkg::CH_AT;
      end
      mse_pkg::OP_HELD_A: begin
        store_en   = 1'b1;
        store_char = match_upper ? mse_pkg::CH_UP_A : mse_pkg::CH_LO_A;
      end
      mse_pkg::OP_HELD_T: begin
        store_en   = 1'b1;
        store_char = match_upper ? mse_pkg::CH_UP_T : mse_pkg::CH_LO_T;
      end
      mse_pkg::OP_PROCESS: begin
        store_en = plain_char;
      end
      default: begin
      end
    endcase
  end

  assign do_store = store_en && !chop_valid;
  assign do_write = do_store && (write_index < IDX_W'(ADDR_CHARS));

  // Visible length and the outcome of the line.
  assign addr_len = chop_valid ? chop_index : write_index;

  always_comb begin
    if (addr_len == '0) begin
      eval_status = mse_pkg::ST_EMPTY;
    end else if (unsafe_seen) begin
      eval_status = mse_pkg::ST_UNSAFE;
    end else if (overflow_seen) begin
      eval_status = mse_pkg::ST_LONG;
    end else begin
      eval_status = mse_pkg::ST_OK;
    end
  end

  assign emit_last = ((rd_index + IDX_W'(1)) == addr_len);
  assign out_free  = !out_valid || out_ready;
  assign clear_now = (cmd.op == mse_pkg::OP_EMIT_ERR) ||
                     ((cmd.op == mse_pkg::OP_EMIT_CHAR) && emit_last);

  // Status towards the controller.
  always_comb begin
    sts.finished       = finished;
    sts.match_progress = match_progress;
    sts.eval_ok        = (eval_status == mse_pkg::ST_OK);
    sts.emit_last      = emit_last;
    sts.out_free       = out_free;
    case (match_progress)
      mse_pkg::MP_SPACE: begin
        sts.match_hit = (char_q == mse_pkg::CH_LO_A) || (char_q == mse_pkg::CH_UP_A);
      end
      mse_pkg::MP_A: begin
        sts.match_hit = (char_q == (match_upper ? mse_pkg::CH_UP_T : mse_pkg::CH_LO_T));
      end
      mse_pkg::MP_AT: begin
        sts.match_hit = (char_q == mse_pkg::CH_SPACE);
      end
      default: begin
        sts.match_hit = 1'b0;
      end
    endcase
  end

  // Buffer write and registered read.
  always_ff @(posedge clk) begin
    if (do_write) begin
      addr_buffer[write_index[AW-1:0]] <= store_char;
    end
    rd_data <= addr_buffer[rd_index[AW-1:0]];
  end

  // Captured character and result payload.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_q <= char_byte;
    end
    if (cmd.op == mse_pkg::OP_EMIT_ERR) begin
      addr_char <= 8'd0;
      status    <= eval_status;
      last_char <= 1'b1;
    end else if (cmd.op == mse_pkg::OP_EMIT_CHAR) begin
      addr_char <= rd_data;
      status    <= mse_pkg::ST_OK;
      last_char <= emit_last;
    end
  end

  // Parse state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      chop_valid     <= 1'b0;
      chop_index     <= '0;
      comment_depth  <= 8'd0;
      in_angle       <= 1'b0;
      finished       <= 1'b0;
      match_progress <= mse_pkg::MP_IDLE;
      match_upper    <= 1'b0;
      unsafe_seen    <= 1'b0;
      overflow_seen  <= 1'b0;
      rd_index       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Effects of a buffer store.
      if (do_store) begin
        if (mse_pkg::is_unsafe(store_char)) begin
          unsafe_seen <= 1'b1;
        end
        if (do_write) begin
          write_index <= write_index + IDX_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      case (cmd.op)
        mse_pkg::OP_MATCH: begin
          case (match_progress)
            mse_pkg::MP_SPACE: begin
              match_progress <= mse_pkg::MP_A;
              match_upper    <= (char_q == mse_pkg::CH_UP_A);
            end
            mse_pkg::MP_A: begin
              match_progress <= mse_pkg::MP_AT;
            end
            default: begin
              match_progress <= mse_pkg::MP_IDLE;
            end
          endcase
        end
        mse_pkg::OP_PROCESS: begin
          match_progress <= mse_pkg::MP_IDLE;
          if (char_q == mse_pkg::CH_NUL) begin
            finished <= 1'b1;
          end else if (comment_depth != 8'd0) begin
            if (char_q == mse_pkg::CH_RPAREN) begin
              comment_depth <= comment_depth - 8'd1;
            end else if ((char_q == mse_pkg::CH_LPAREN) &&
                         (comment_depth != mse_pkg::CH_MAX_DEPTH)) begin
              comment_depth <= comment_depth + 8'd1;
            end
          end else if (in_angle && (char_q == mse_pkg::CH_GT)) begin
            finished <= 1'b1;
          end else begin
            case (char_q)
              mse_pkg::CH_SPACE: begin
                match_progress <= mse_pkg::MP_SPACE;
              end
              mse_pkg::CH_LT: begin
                // A new '<' starts the address afresh.
                in_angle      <= 1'b1;
                write_index   <= '0;
                chop_valid    <= 1'b0;
                chop_index    <= '0;
                unsafe_seen   <= 1'b0;
                overflow_seen <= 1'b0;
              end
              mse_pkg::CH_LPAREN: begin
                comment_depth <= 8'd1;
              end
              mse_pkg::CH_COMMA: begin
                if (!chop_valid) begin
                  chop_valid <= 1'b1;
                  chop_index <= write_index;
                end
              end
              default: begin
              end
            endcase
          end
        end
        mse_pkg::OP_EMIT_ERR: begin
          out_valid <= 1'b1;
        end
        mse_pkg::OP_EMIT_CHAR: begin
          out_valid <= 1'b1;
          rd_index  <= rd_index + IDX_W'(1);
        end
        default: begin
        end
      endcase

      // The last result of a line clears the state for the next one.
      if (clear_now) begin
        write_index    <= '0;
        chop_valid     <= 1'b0;
        chop_index     <= '0;
        comment_depth  <= 8'd0;
        in_angle       <= 1'b0;
        finished       <= 1'b0;
        match_progress <= mse_pkg::MP_IDLE;
        match_upper    <= 1'b0;
        unsafe_seen    <= 1'b0;
        overflow_seen  <= 1'b0;
        rd_index       <= '0;
      end
    end
  end

  // Checks on the buffer bookkeeping and the result register.
  `MSE_ASSERT_SAME(a_index_bound, clk, rst, 1'b1, write_index <= IDX_W'(ADDR_CHARS), "write index beyond buffer")
  `MSE_ASSERT_SAME(a_chop_bound, clk, rst, chop_valid, chop_index <= write_index, "chop index beyond write index")
  `MSE_ASSERT_SAME(a_load_free, clk, rst, (cmd.op == mse_pkg::OP_EMIT_ERR) || (cmd.op == mse_pkg::OP_EMIT_CHAR), out_free, "result loaded while output busy")
  `MSE_ASSERT_NEXT(a_clear_line, clk, rst, clear_now, (write_index == '0) && !finished && (rd_index == '0), "line state not cleared after last result")

endmodule

// File: rtl/mail_sender_address_extractor_top.sv
// Top level of the sender address extractor: controller, datapath and channel wiring.
// Depends on mse_pkg, mse_in_if, mse_out_if, mse_ctrl and mse_datapath.

// Takes the characters of one From line, one transfer each, then an end item, and
// delivers the sender address one character per transfer (status ok, last_char on the
// final one) or a single error transfer. Input is accepted only while the controller is
// idle, so a new item is taken only once the last one is through. A character item takes
// the match step, and a held "a"/"at" of a failed at-word match is replayed in steps of
// its own, since the address buffer has one write port. An end item flushes held letters
// and evaluates the line, then each address character passes a read state and a load
// state, set by the registered read of the buffer; an error result is loaded in the
// evaluation state itself. A stalled output holds the controller in the evaluation or
// load state. The buffer holds ADDR_CHARS characters and needs no clearing pass.
module mail_sender_address_extractor_top #(
  parameter int ADDR_CHARS = 64
) (
  input logic       clk,
  input logic       rst,
  mse_in_if.sink    line_in,
  mse_out_if.source addr_out
);

  mse_pkg::mse_cmd_t cmd;
  mse_pkg::mse_sts_t sts;
  logic              in_ready;

  assign line_in.ready = in_ready;

  // Item sequencing.
  mse_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (line_in.valid),
    .in_end_of_line (line_in.end_of_line),
    .in_ready       (in_ready),
    .sts            (sts),
    .cmd            (cmd)
  );

  // Parse state, buffer and result register.
  mse_datapath #(
    .ADDR_CHARS (ADDR_CHARS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .char_byte (line_in.char_byte),
    .out_ready (addr_out.ready),
    .out_valid (addr_out.valid),
    .addr_char (addr_out.addr_char),
    .status    (addr_out.status),
    .last_char (addr_out.last_char)
  );

endmodule
